/* src/tssp_pkg.sv */
package tssp_pkg;

   localparam int NUM_AXIS        = 4;
   localparam int AXIS_W          = 2;
   localparam int RAMP_SEGS       = 20;
   localparam int R_W             = 5;
   localparam int STEP_CLOCK_HZ   = 1000000;
   localparam int MIN_HALF_PERIOD = 2;
   localparam int MIN_START_SPEED = 100;
   localparam int HP_MAX          = 524287;
   localparam int ACCEL_RESET     = 10000;

   localparam int ACC_W   = 20;
   localparam int SPEED_W = 18;
   localparam int HP_W    = 19;
   localparam int CNT_W   = 31;
   localparam int POS_W   = 32;
   localparam int MUL_W   = 36;
   localparam int DIV_N   = 36;
   localparam int DIVS_W  = 21;
   localparam int ITER_W  = 6;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 88;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 3'd4;

   localparam logic REQ_MOVE = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_SQ     = 16'h0002,
      S_UPLD   = 16'h0004,
      S_DIV    = 16'h0008,
      S_CLIP   = 16'h0010,
      S_START  = 16'h0020,
      S_PERU   = 16'h0040,
      S_LASTU  = 16'h0080,
      S_PERD   = 16'h0100,
      S_LASTD  = 16'h0200,
      S_SEGMUL = 16'h0400,
      S_SEGLD  = 16'h0800,
      S_SEGV   = 16'h1000,
      S_HPLD   = 16'h2000,
      S_HP     = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      PH_UP     = 2'd0,
      PH_CRUISE = 2'd1,
      PH_DOWN   = 2'd2
   } phase_type;

endpackage

/* src/trapezoid_step_segment_planner_unit.sv */
// Channel  | Direction | Handshake           | Payload
// request  | in        | req_tvalid/tready   | req_tdata, req_tuser
// segment  | out       | rsp_tvalid/tready   | rsp_tdata, rsp_tlast
// csr      | in        | csr_valid/ready     | csr_index, csr_data
//
// One shared restoring divider (one quotient bit per cycle) and one multiplier do
// all the arithmetic under a small sequencer.
// A move runs its setup arithmetic and then gives up to 41 segments; a set-position
// request only loads the position register and gives no segment.
// Reset is synchronous, clears positions and the sequencer and restores the
// default accelerations.
// A stalled segment holds in the output register until it is taken.
module trapezoid_step_segment_planner_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // axis_index, step_count, cruise_speed, zero fill
   input  logic [tssp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // axis_tag, dir_level, half step period, pulse_count, position_after, zero fill
   output logic [tssp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tssp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tssp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tssp_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   phase_type phase_ff, phase_in;

   logic [ACC_W-1:0]   acc_ff [NUM_AXIS];
   logic [ACC_W-1:0]   acc_in [NUM_AXIS];
   logic [POS_W-1:0]   pos_ff [NUM_AXIS];
   logic [POS_W-1:0]   pos_in [NUM_AXIS];
   logic [NUM_AXIS-1:0] inv_ff, inv_in;

   logic [AXIS_W-1:0]  axis_ff, axis_in;
   logic               dir_ff, dir_in;
   logic [CNT_W-1:0]   m_ff, m_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [SPEED_W-1:0] start_ff, start_in;
   logic [SPEED_W-1:0] v_ff, v_in;
   logic [CNT_W-1:0]   up_ff, up_in, down_ff, down_in, cruise_ff, cruise_in;
   logic [CNT_W-1:0]   peru_ff, peru_in, perd_ff, perd_in;
   logic [CNT_W-1:0]   lastu_ff, lastu_in, lastd_ff, lastd_in;
   logic [R_W-1:0]     r_ff, r_in, k_ff, k_in;
   logic [POS_W-1:0]   posa_ff, posa_in;
   logic [HP_W-1:0]    hp_ff, hp_in;
   logic [CNT_W-1:0]   pc_ff, pc_in;
   logic               last_ff, last_in;
   logic [MUL_W-1:0]   mul_ff, mul_in;
   logic [DIV_N-1:0]   quo_ff, quo_in;
   logic [DIVS_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;

   logic [AXIS_W-1:0]  r_axis;
   logic [POS_W-1:0]   r_step, r_neg, new_pos;
   logic [SPEED_W-1:0] r_speed;
   logic [ACC_W-1:0]   acc_sel;
   logic [CNT_W-1:0]   op_a;
   logic [SPEED_W-1:0] op_b;
   logic [48:0]        prod;
   logic               div_go;
   logic [DIV_N-1:0]   div_a;
   logic [DIVS_W-1:0]  div_b;
   state_type          div_ret;
   logic [DIVS_W:0]    rem_sh, rem_sub;
   logic               rem_ge;
   logic [CNT_W-1:0]   half_m, up_c, down_c;
   logic               dneg;
   logic [SPEED_W-1:0] dmag;
   logic [SPEED_W:0]   v_sum;

   assign r_axis  = req_tdata[1:0];
   assign r_step  = req_tdata[33:2];
   assign r_speed = req_tdata[51:34];
   assign r_neg   = POS_W'(0) - r_step;
   assign new_pos = pos_ff[r_axis] + r_step;
   assign acc_sel = (acc_ff[axis_ff] == '0) ? ACC_W'(1) : acc_ff[axis_ff];
   assign half_m  = {1'b0, m_ff[CNT_W-1:1]};
   assign dneg    = speed_ff < start_ff;
   assign dmag    = dneg ? (start_ff - speed_ff) : (speed_ff - start_ff);
   assign prod    = op_a * op_b;
   assign rem_sh  = {rem_ff, quo_ff[DIV_N-1]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign rem_ge  = rem_sh >= {1'b0, dvs_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {3'b000, posa_ff, pc_ff, hp_ff, dir_ff, axis_ff};

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      inv_in    = inv_ff;
      axis_in   = axis_ff;
      dir_in    = dir_ff;
      m_in      = m_ff;
      speed_in  = speed_ff;
      start_in  = start_ff;
      v_in      = v_ff;
      up_in     = up_ff;
      down_in   = down_ff;
      cruise_in = cruise_ff;
      peru_in   = peru_ff;
      perd_in   = perd_ff;
      lastu_in  = lastu_ff;
      lastd_in  = lastd_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      posa_in   = posa_ff;
      hp_in     = hp_ff;
      pc_in     = pc_ff;
      last_in   = last_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      iter_in   = iter_ff;
      op_a      = '0;
      op_b      = '0;
      div_go    = 1'b0;
      div_a     = '0;
      div_b     = '0;
      div_ret   = S_IDLE;
      up_c      = '0;
      down_c    = '0;
      v_sum     = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL0: acc_in[0] = csr_data;
            CSR_ACCEL1: acc_in[1] = csr_data;
            CSR_ACCEL2: acc_in[2] = csr_data;
            CSR_ACCEL3: acc_in[3] = csr_data;
            CSR_INVERT: inv_in = csr_data[NUM_AXIS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_SET) begin
                  pos_in[r_axis] = r_step;
               end else if (r_step != '0) begin
                  pos_in[r_axis] = new_pos;
                  posa_in  = new_pos;
                  axis_in  = r_axis;
                  speed_in = r_speed;
                  if (r_step[POS_W-1]) begin
                     m_in   = r_neg[POS_W-1] ? {CNT_W{1'b1}} : r_neg[CNT_W-1:0];
                     dir_in = inv_ff[r_axis];
                  end else begin
                     m_in   = r_step[CNT_W-1:0];
                     dir_in = ~inv_ff[r_axis];
                  end
                  if (r_speed != '0) begin
                     state_in = S_SQ;
                  end
               end
            end
         end
         S_SQ: begin
            op_a     = CNT_W'(speed_ff);
            op_b     = speed_ff;
            state_in = S_UPLD;
         end
         S_UPLD: begin
            div_go  = 1'b1;
            div_a   = mul_ff;
            div_b   = {acc_sel, 1'b0};
            div_ret = S_CLIP;
         end
         S_DIV: begin
            rem_in  = rem_ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            quo_in  = {quo_ff[DIV_N-2:0], rem_ge};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = ret_ff;
            end
         end
         S_CLIP: begin
            if (quo_ff > DIV_N'(half_m)) begin
               up_c   = half_m;
               down_c = m_ff - half_m;
            end else begin
               up_c   = quo_ff[CNT_W-1:0];
               down_c = quo_ff[CNT_W-1:0];
            end
            up_in     = up_c;
            down_in   = down_c;
            cruise_in = m_ff - up_c - down_c;
            if (up_c == '0) begin
               // A move with no up ramp (such as a one-step move) runs all its steps at cruise speed.
               down_in   = '0;
               cruise_in = m_ff;
               r_in      = R_W'(RAMP_SEGS);
               phase_in  = PH_CRUISE;
               state_in  = S_SEGMUL;
            end else begin
               r_in    = (up_c < CNT_W'(RAMP_SEGS)) ? up_c[R_W-1:0] : R_W'(RAMP_SEGS);
               div_go  = 1'b1;
               div_a   = DIV_N'(speed_ff);
               div_b   = (up_c < CNT_W'(RAMP_SEGS)) ? DIVS_W'(up_c[R_W-1:0])
                                                    : DIVS_W'(RAMP_SEGS);
               div_ret = S_START;
            end
         end
         S_START: begin
            start_in = (quo_ff < DIV_N'(MIN_START_SPEED)) ? SPEED_W'(MIN_START_SPEED)
                                                           : quo_ff[SPEED_W-1:0];
            div_go   = 1'b1;
            div_a    = DIV_N'(up_ff);
            div_b    = DIVS_W'(r_ff);
            div_ret  = S_PERU;
         end
         S_PERU: begin
            peru_in  = quo_ff[CNT_W-1:0];
            op_a     = quo_ff[CNT_W-1:0];
            op_b     = SPEED_W'(r_ff - R_W'(1));
            state_in = S_LASTU;
         end
         S_LASTU: begin
            lastu_in = up_ff - mul_ff[CNT_W-1:0];
            div_go   = 1'b1;
            div_a    = DIV_N'(down_ff);
            div_b    = DIVS_W'(r_ff);
            div_ret  = S_PERD;
         end
         S_PERD: begin
            perd_in  = quo_ff[CNT_W-1:0];
            op_a     = quo_ff[CNT_W-1:0];
            op_b     = SPEED_W'(r_ff - R_W'(1));
            state_in = S_LASTD;
         end
         S_LASTD: begin
            lastd_in = down_ff - mul_ff[CNT_W-1:0];
            phase_in = PH_UP;
            k_in     = R_W'(1);
            state_in = S_SEGMUL;
         end
         S_SEGMUL: begin
            if (phase_ff == PH_CRUISE) begin
               v_in     = speed_ff;
               state_in = S_HPLD;
            end else begin
               op_a     = CNT_W'(dmag);
               op_b     = SPEED_W'(k_ff);
               state_in = S_SEGLD;
            end
         end
         S_SEGLD: begin
            div_go  = 1'b1;
            div_a   = mul_ff;
            div_b   = DIVS_W'(r_ff);
            div_ret = S_SEGV;
         end
         S_SEGV: begin
            if (dneg) begin
               v_sum = {1'b0, start_ff} - {1'b0, quo_ff[SPEED_W-1:0]};
            end else begin
               v_sum = {1'b0, start_ff} + {1'b0, quo_ff[SPEED_W-1:0]};
            end
            v_in     = v_sum[SPEED_W-1:0];
            state_in = S_HPLD;
         end
         S_HPLD: begin
            div_go  = 1'b1;
            div_a   = DIV_N'(STEP_CLOCK_HZ);
            div_b   = {2'b00, v_ff, 1'b0};
            div_ret = S_HP;
         end
         S_HP: begin
            if (quo_ff < DIV_N'(MIN_HALF_PERIOD)) begin
               hp_in = HP_W'(MIN_HALF_PERIOD);
            end else if (quo_ff > DIV_N'(HP_MAX)) begin
               hp_in = HP_W'(HP_MAX);
            end else begin
               hp_in = quo_ff[HP_W-1:0];
            end
            case (phase_ff)
               PH_UP: begin
                  pc_in   = (k_ff == r_ff) ? lastu_ff : peru_ff;
                  last_in = 1'b0;
               end
               PH_CRUISE: begin
                  pc_in   = cruise_ff;
                  last_in = (down_ff == '0);
               end
               default: begin
                  pc_in   = (k_ff == R_W'(1)) ? lastd_ff : perd_ff;
                  last_in = (k_ff == R_W'(1));
               end
            endcase
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_SEGMUL;
               case (phase_ff)
                  PH_UP: begin
                     if (k_ff != r_ff) begin
                        k_in = k_ff + R_W'(1);
                     end else if (cruise_ff != '0) begin
                        phase_in = PH_CRUISE;
                     end else begin
                        phase_in = PH_DOWN;
                        k_in     = r_ff;
                     end
                  end
                  PH_CRUISE: begin
                     if (down_ff != '0) begin
                        phase_in = PH_DOWN;
                        k_in     = r_ff;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     if (k_ff != R_W'(1)) begin
                        k_in = k_ff - R_W'(1);
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (div_go) begin
         quo_in   = div_a;
         rem_in   = '0;
         dvs_in   = div_b;
         iter_in  = ITER_W'(DIV_N);
         ret_in   = div_ret;
         state_in = S_DIV;
      end
      mul_in = prod[MUL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         phase_ff <= PH_UP;
         inv_ff   <= '0;
         for (int i = 0; i < NUM_AXIS; i++) begin
            acc_ff[i] <= ACC_W'(ACCEL_RESET);
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         phase_ff <= phase_in;
         inv_ff   <= inv_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      dir_ff    <= dir_in;
      m_ff      <= m_in;
      speed_ff  <= speed_in;
      start_ff  <= start_in;
      v_ff      <= v_in;
      up_ff     <= up_in;
      down_ff   <= down_in;
      cruise_ff <= cruise_in;
      peru_ff   <= peru_in;
      perd_ff   <= perd_in;
      lastu_ff  <= lastu_in;
      lastd_ff  <= lastd_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      posa_ff   <= posa_in;
      hp_ff     <= hp_in;
      pc_ff     <= pc_in;
      last_ff   <= last_in;
      mul_ff    <= mul_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      iter_ff   <= iter_in;
   end

endmodule

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tssp_pkg::*;

   localparam longint LIMIT = 20000000;
   localparam int SETTLE = 4000;

   typedef struct packed {
      logic [1:0]  axis;
      logic        dir;
      logic [18:0] hp;
      logic [30:0] cnt;
      logic [31:0] pos;
      logic        last;
   } segment_type;

   typedef struct {
      logic        kind;
      logic [1:0]  axis;
      logic [31:0] steps;
      logic [17:0] speed;
      bit          none_expected;
   } command_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   segment_type segment_queue[$];
   longint ramp_speeds[$], ramp_counts[$];
   logic [19:0] accel_shadow[4];
   logic [3:0]  invert_shadow;
   logic [31:0] position_shadow[4];
   int mismatches;
   longint cycles;
   int requests_sent;
   bit hold_pending;

   trapezoid_step_segment_planner_unit dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic longint ramp_speed(longint start, longint speed, longint k, longint r);
      longint v;
      v = start + ((speed - start) * k) / r;
      return v < 0 ? 0 : v;
   endfunction

   function automatic void add_ramp(longint speed, longint count);
      if (speed != 0 && count != 0 && ramp_speeds.size() < 41) begin
         ramp_speeds.push_back(speed);
         ramp_counts.push_back(count);
      end
   endfunction

   function automatic void plan_command(command_type c);
      longint m, acc, up, down, cruise, r, start, per, hp, spd;
      logic [31:0] neg;
      logic dir;
      segment_type s;
      if (c.kind == REQ_SET) begin
         position_shadow[c.axis] = c.steps;
         return;
      end
      if (c.steps == 0) return;
      spd = c.speed;
      if (c.steps[31]) begin
         neg = -c.steps;
         m = neg;
         if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
         dir = 1'b0;
      end else begin
         m = c.steps;
         dir = 1'b1;
      end
      dir ^= invert_shadow[c.axis];
      acc = accel_shadow[c.axis];
      if (acc == 0) acc = 1;
      up = spd * spd / (2 * acc);
      if (2 * up > m) begin
         up = m / 2;
         down = m - up;
      end else begin
         down = up;
      end
      cruise = m - up - down;
      r = RAMP_SEGS;
      if (up > 0 && r > up) r = up;
      if (down > 0 && r > down) r = down;
      start = spd / r;
      if (start < MIN_START_SPEED) start = MIN_START_SPEED;
      ramp_speeds.delete();
      ramp_counts.delete();
      if (up > 0) begin
         per = up / r;
         if (per < 1) per = 1;
         for (longint k = 1; k <= r; k++)
            add_ramp(ramp_speed(start, spd, k, r), k == r ? up - per * (r - 1) : per);
      end
      if (cruise > 0) add_ramp(spd, cruise);
      if (down > 0) begin
         per = down / r;
         if (per < 1) per = 1;
         for (longint k = r; k >= 1; k--)
            add_ramp(ramp_speed(start, spd, k, r), k == 1 ? down - per * (r - 1) : per);
      end
      position_shadow[c.axis] += c.steps;
      foreach (ramp_speeds[i]) begin
         hp = STEP_CLOCK_HZ / (ramp_speeds[i] * 2);
         if (hp < MIN_HALF_PERIOD) hp = MIN_HALF_PERIOD;
         if (hp > HP_MAX) hp = HP_MAX;
         s.axis = c.axis;
         s.dir = dir;
         s.hp = hp[18:0];
         s.cnt = ramp_counts[i][30:0];
         s.pos = position_shadow[c.axis];
         s.last = (i == ramp_speeds.size() - 1);
         segment_queue.push_back(s);
      end
   endfunction

   task automatic send_command(command_type c);
      int queued;
      req_tvalid <= 1'b1;
      req_tuser <= c.kind;
      req_tdata <= {4'b0, c.speed, c.steps, c.axis};
      do @(posedge clock); while (!req_tready);
      queued = segment_queue.size();
      plan_command(c);
      if (c.none_expected && segment_queue.size() != queued) begin
         mismatches++;
         if (mismatches <= 10)
            $display("request %0d: expected no segments, predicted %0d",
                     requests_sent, segment_queue.size() - queued);
      end
      requests_sent++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_INVERT) invert_shadow = value[3:0];
      else accel_shadow[idx] = value;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (segment_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   function automatic command_type random_command();
      command_type c;
      c.none_expected = 0;
      c.kind = ($urandom_range(0, 9) < 3) ? REQ_SET : REQ_MOVE;
      c.axis = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: c.steps = $urandom;
         1: c.steps = $urandom_range(1, 100000);
         default: c.steps = $urandom_range(1, 2000);
      endcase
      if (c.kind == REQ_MOVE && $urandom_range(0, 1)) c.steps = -c.steps;
      case ($urandom_range(0, 4))
         0: c.speed = 18'($urandom);
         1: c.speed = '0;
         default: c.speed = 18'($urandom_range(1, 3000));
      endcase
      return c;
   endfunction

   always @(posedge clock) begin
      segment_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.axis = rsp_tdata[1:0];
         a.dir = rsp_tdata[2];
         a.hp = rsp_tdata[21:3];
         a.cnt = rsp_tdata[52:22];
         a.pos = rsp_tdata[84:53];
         a.last = rsp_tlast;
         if (segment_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected segment %p", a);
         end else begin
            e = segment_queue.pop_front();
            if (e !== a) begin
               mismatches++;
               if (mismatches <= 10) $display("segment mismatch: expected %p, got %p", e, a);
            end
         end
      end
   end

   initial begin
      int stall_pct;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 80);
         repeat ($urandom_range(50, 400)) begin
            @(posedge clock);
            if (hold_pending) begin
               hold_pending = 0;
               rsp_tready <= 1'b0;
               repeat (3000) @(posedge clock);
            end
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin
      command_type table_rows[$];
      logic [19:0] accel_set[4];
      logic [3:0]  invert_set;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      cycles = 0;
      requests_sent = 0;
      hold_pending = 0;
      for (int i = 0; i < 4; i++) begin
         accel_shadow[i] = 20'(ACCEL_RESET);
         position_shadow[i] = '0;
      end
      invert_shadow = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      table_rows = '{
         '{REQ_MOVE, 2'd0, 32'd1,          18'd1000,   0},
         '{REQ_SET,  2'd0, 32'd100,        18'd0,      1},
         '{REQ_MOVE, 2'd0, 32'd0,          18'd2000,   1},
         '{REQ_MOVE, 2'd1, 32'd500,        18'd0,      1},
         '{REQ_MOVE, 2'd1, 32'h80000000,   18'd500,    0},
         '{REQ_MOVE, 2'd2, 32'h7FFFFFFF,   18'h3FFFF,  0},
         '{REQ_SET,  2'd3, 32'h7FFFFFFF,   18'h3FFFF,  1},
         '{REQ_MOVE, 2'd3, 32'd1,          18'd1,      0},
         '{REQ_MOVE, 2'd3, -32'sd2,        18'd2000,   0},
         '{REQ_MOVE, 2'd0, 32'd1000,       18'd2000,   0},
         '{REQ_MOVE, 2'd1, -32'sd1000,     18'd2000,   0},
         '{REQ_MOVE, 2'd2, 32'd5,          18'h3FFFF,  0},
         '{REQ_MOVE, 2'd0, 32'd3,          18'd99,     0},
         '{REQ_SET,  2'd1, 32'hFFFFFFFF,   18'd0,      1},
         '{REQ_SET,  2'd2, 32'h80000000,   18'd0,      1},
         '{REQ_MOVE, 2'd2, -32'sd7,        18'd300,    0},
         '{REQ_MOVE, 2'd1, 32'd40,         18'd700,    0},
         '{REQ_SET,  2'd0, 32'h0,          18'd0,      1}
      };
      foreach (table_rows[i]) begin
         send_command(table_rows[i]);
         sender_gap();
      end

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         for (int i = 0; i < 4; i++)
            accel_set[i] = phase == 0 ? 20'd0 : phase == 1 ? 20'hFFFFF :
                           phase == 2 ? 20'd1 : 20'($urandom);
         invert_set = phase == 0 ? 4'hF : phase == 1 ? 4'h0 : 4'($urandom);
         if (phase == 3) accel_set[0] = 20'(ACCEL_RESET);
         for (int i = 0; i < 4; i++) write_csr(CSR_IDX_W'(i), accel_set[i]);
         write_csr(CSR_INVERT, {16'b0, invert_set});
         csr_valid <= 1'b0;
         @(posedge clock);
         repeat (70) begin
            send_command(random_command());
            if (requests_sent == 150) hold_pending = 1;
            if ($urandom_range(0, 4) == 0) sender_gap();
         end
      end

      req_tvalid <= 1'b0;
      while (segment_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

/* trapezoid_step_segment_planner_unit.f */
src/tssp_pkg.sv
src/trapezoid_step_segment_planner_unit.sv
test/tb_top.sv
